/* rtl/core/stereo_disparity_triangulation_assert.svh */
// assertion helpers for the triangulation pipeline
`ifndef STEREO_DISPARITY_TRIANGULATION_ASSERT_SVH
`define STEREO_DISPARITY_TRIANGULATION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangulation check failed");

// next-cycle implication, checked out of reset
`define SDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangulation check failed");

`endif

/* rtl/core/sdt_pkg.sv */
`default_nettype none
package sdt_pkg;

  // fixed point formats
  localparam int PIXEL_FRAC_BITS = 4;
  localparam int OUT_FRAC_BITS   = 12;
  localparam int INDEX_BITS      = 12;
  localparam int SCALE_SHIFT     = OUT_FRAC_BITS + PIXEL_FRAC_BITS - 8;

  // field widths
  localparam int BF_W  = 24;
  localparam int PIX_W = 16;
  localparam int PROD_W = BF_W + PIX_W;

  // divider sizing: numerator carries one extra bit for rounding
  localparam int NUM_W      = PROD_W + SCALE_SHIFT + 1;
  localparam int DEN_W      = 2 * PIX_W;
  localparam int DIV_STAGES = NUM_W;

  // register reset values
  localparam logic [BF_W-1:0]  BF_RESET   = 24'd98816;
  localparam logic [PIX_W-1:0] FL_RESET   = 16'd11488;
  localparam logic [PIX_W-1:0] CCOL_RESET = 16'd9670;
  localparam logic [PIX_W-1:0] CROW_RESET = 16'd2969;

  // register map
  typedef enum logic [1:0] {
    REG_BASELINE_FOCAL,
    REG_FOCAL_LENGTH,
    REG_CENTER_COLUMN,
    REG_CENTER_ROW
  } reg_idx_t;

endpackage
`default_nettype wire

/* rtl/core/stereo_disparity_triangulation.sv */
// pipeline: 2 front stages, one divider stage per quotient bit, one output stage
// throughput: one beat per cycle; the whole pipeline advances together and
//   holds while a finished result waits under out_stall
// reset: synchronous, clears all valid bits and loads the register defaults
`default_nettype none
`include "stereo_disparity_triangulation_assert.svh"
module stereo_disparity_triangulation
  import sdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      left_col,
  input  wire logic [PIX_W-1:0]      left_row,
  input  wire logic [PIX_W-1:0]      right_col,
  input  wire logic [INDEX_BITS-1:0] left_index,
  input  wire logic [INDEX_BITS-1:0] right_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       valid_res,
  output logic signed [31:0]         point_x,
  output logic signed [31:0]         point_y,
  output logic      [30:0]           point_z,
  output logic      [INDEX_BITS-1:0] out_left_index,
  output logic      [INDEX_BITS-1:0] out_right_index
);

  typedef struct packed {
    logic                  valid;
    logic                  ok;
    logic                  negx;
    logic                  negy;
    logic [INDEX_BITS-1:0] li;
    logic [INDEX_BITS-1:0] ri;
  } side_t;

  logic [BF_W-1:0]  baseline_focal;
  logic [PIX_W-1:0] focal_length;
  logic [PIX_W-1:0] center_column;
  logic [PIX_W-1:0] center_row;
  logic             en;

  // config writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_focal <= BF_RESET;
      focal_length   <= FL_RESET;
      center_column  <= CCOL_RESET;
      center_row     <= CROW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_BASELINE_FOCAL: baseline_focal <= pwdata[BF_W-1:0];
        REG_FOCAL_LENGTH:   focal_length   <= pwdata[PIX_W-1:0];
        REG_CENTER_COLUMN:  center_column  <= pwdata[PIX_W-1:0];
        REG_CENTER_ROW:     center_row     <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_BASELINE_FOCAL: prdata = {{(32-BF_W){1'b0}}, baseline_focal};
      REG_FOCAL_LENGTH:   prdata = {{(32-PIX_W){1'b0}}, focal_length};
      REG_CENTER_COLUMN:  prdata = {{(32-PIX_W){1'b0}}, center_column};
      REG_CENTER_ROW:     prdata = {{(32-PIX_W){1'b0}}, center_row};
      default:            prdata = '0;
    endcase
  end

  // global advance: hold only when the output beat is blocked
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: disparity and offsets from the principal point
  logic [PIX_W:0]   dsub, xsub, ysub;
  logic             s1_valid, s1_ok, s1_negx, s1_negy;
  logic [PIX_W-1:0] s1_disp, s1_magx, s1_magy;
  logic [INDEX_BITS-1:0] s1_li, s1_ri;

  always_comb begin
    dsub = {1'b0, left_col} - {1'b0, right_col};
    xsub = {1'b0, left_col} - {1'b0, center_column};
    ysub = {1'b0, left_row} - {1'b0, center_row};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok   <= !dsub[PIX_W] && (dsub != '0) && (focal_length != '0);
      s1_disp <= dsub[PIX_W-1:0];
      s1_negx <= xsub[PIX_W];
      s1_magx <= xsub[PIX_W] ? (~xsub[PIX_W-1:0] + 1'b1) : xsub[PIX_W-1:0];
      s1_negy <= ysub[PIX_W];
      s1_magy <= ysub[PIX_W] ? (~ysub[PIX_W-1:0] + 1'b1) : ysub[PIX_W-1:0];
      s1_li   <= left_index;
      s1_ri   <= right_index;
    end
  end

  // stage 2: numerator products and denominator
  logic [PROD_W-1:0] s2_prodx, s2_prody;
  logic [DEN_W-1:0]  s2_den;
  logic [PIX_W-1:0]  s2_disp;
  side_t             s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (en) begin
      s2_side.valid <= s1_valid;
      s2_side.ok    <= s1_ok;
      s2_side.negx  <= s1_negx;
      s2_side.negy  <= s1_negy;
      s2_side.li    <= s1_li;
      s2_side.ri    <= s1_ri;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prodx     <= baseline_focal * s1_magx;
      s2_prody     <= baseline_focal * s1_magy;
      s2_den       <= s1_disp * focal_length;
      s2_disp      <= s1_disp;
    end
  end

  // dividers: doubled numerators give one extra quotient bit for rounding
  logic [NUM_W-1:0] qx, qy, qz;

  sdt_div u_div_x (
    .clk (clk),
    .en  (en),
    .num ({s2_prodx, {(SCALE_SHIFT+1){1'b0}}}),
    .den (s2_den),
    .quo (qx)
  );

  sdt_div u_div_y (
    .clk (clk),
    .en  (en),
    .num ({s2_prody, {(SCALE_SHIFT+1){1'b0}}}),
    .den (s2_den),
    .quo (qy)
  );

  sdt_div u_div_z (
    .clk (clk),
    .en  (en),
    .num ({{(NUM_W-BF_W-SCALE_SHIFT-1){1'b0}}, baseline_focal,
           {(SCALE_SHIFT+1){1'b0}}}),
    .den ({{(DEN_W-PIX_W){1'b0}}, s2_disp}),
    .quo (qz)
  );

  // sideband travels alongside the divider stages
  side_t side_q [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        side_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_q[0] <= s2_side;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // rounding and saturation
  logic [NUM_W:0] rx, ry, rz;
  logic [NUM_W-1:0] mx, my, mz;
  logic [31:0] sx, sy;
  logic [30:0] sz;
  side_t last;

  always_comb begin
    last = side_q[DIV_STAGES-1];
    rx = {1'b0, qx} + 1'b1;
    ry = {1'b0, qy} + 1'b1;
    rz = {1'b0, qz} + 1'b1;
    mx = rx[NUM_W:1];
    my = ry[NUM_W:1];
    mz = rz[NUM_W:1];
    if (last.negx) begin
      sx = (mx >= NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (~mx[31:0] + 1'b1);
    end else begin
      sx = (mx > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mx[31:0];
    end
    if (last.negy) begin
      sy = (my >= NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : (~my[31:0] + 1'b1);
    end else begin
      sy = (my > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : my[31:0];
    end
    sz = (mz > NUM_W'(64'h7FFF_FFFF)) ? 31'h7FFF_FFFF : mz[30:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      valid_res       <= last.ok;
      point_x         <= last.ok ? sx : 32'd0;
      point_y         <= last.ok ? sy : 32'd0;
      point_z         <= last.ok ? sz : 31'd0;
      out_left_index  <= last.li;
      out_right_index <= last.ri;
    end
  end

  // checks
  `SDT_ASSERT_IMP(a_invalid_zero, out_valid && !valid_res, point_x == 32'd0 && point_y == 32'd0 && point_z == 31'd0)
  `SDT_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(s1_valid) && $stable(s2_side.valid))
  `SDT_ASSERT_IMP(a_zero_bf, out_valid && valid_res && baseline_focal == '0, point_z == 31'd0)

endmodule
`default_nettype wire

/* rtl/core/sdt_div.sv */
`default_nettype none
module sdt_div
  import sdt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);

  // per stage partial remainder, shifting numerator/quotient word, divisor
  logic [DEN_W-1:0] rem_q [DIV_STAGES];
  logic [NUM_W-1:0] w_q   [DIV_STAGES];
  logic [DEN_W-1:0] d_q   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [NUM_W-1:0] w_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign r_in = '0;
      assign d_in = den;
      assign w_in = num;
    end else begin : g_rest
      assign r_in = rem_q[i-1];
      assign d_in = d_q[i-1];
      assign w_in = w_q[i-1];
    end

    // one restoring step: bring down a bit, try the subtract
    always_comb begin
      trial = {r_in, w_in[NUM_W-1]};
      diff  = trial - {1'b0, d_in};
      ge    = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        w_q[i]   <= {w_in[NUM_W-2:0], ge};
        d_q[i]   <= d_in;
      end
    end
  end

  assign quo = w_q[DIV_STAGES-1];

endmodule
`default_nettype wire
